@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define LWBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication shorthand: antecedent then consequent in the same cycle.
`define LWBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `LWBC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

@@ hw/rtl/lwbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lwbc_pkg
// Types, codes and helpers of the LRU write buffer cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lwbc_pkg;

  localparam int unsigned BPB    = 16;
  localparam int unsigned BANKS  = 8;
  localparam int unsigned SLOT_W = $clog2(BPB);
  localparam int unsigned BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int unsigned ADDR_W = BANK_W + SLOT_W;
  localparam int unsigned NSLOTS = BANKS * BPB;
  localparam int unsigned ROW_W  = BPB * SLOT_W;
  localparam int unsigned CNT_W  = $clog2(BPB + 1);

  typedef enum logic [2:0] {
    MODE_WRITE   = 3'd0,
    MODE_FLUSH   = 3'd1,
    MODE_LOOKUP  = 3'd2,
    MODE_CLEAN   = 3'd3,
    MODE_READ    = 3'd4,
    MODE_STALL   = 3'd5,
    MODE_RELEASE = 3'd6
  } lwbc_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_STALL = 2'd2
  } lwbc_status_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  bank;
    logic [3:0]  buffer_index;
    logic [31:0] page_number;
    logic [15:0] page_span;
    logic [31:0] write_epoch;
  } lwbc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [31:0] page_out;
    logic        dirty_out;
    logic [15:0] span_out;
    logic [31:0] epoch_out;
    logic [4:0]  dirty_total;
  } lwbc_out_t;

  // LRU row after reset: slot i at position i.
  function automatic logic [ROW_W-1:0] lru_init();
    logic [ROW_W-1:0] r;
    for (int unsigned i = 0; i < BPB; i++) begin
      r[i*SLOT_W +: SLOT_W] = SLOT_W'(i);
    end
    return r;
  endfunction

  // Move slot to position 0, shifting positions 0..pos-1 down by one.
  function automatic logic [ROW_W-1:0] lru_promote(logic [ROW_W-1:0] row,
                                                    logic [SLOT_W-1:0] pos,
                                                    logic [SLOT_W-1:0] slot);
    logic [ROW_W-1:0] r;
    r = row;
    r[SLOT_W-1:0] = slot;
    for (int unsigned i = 1; i < BPB; i++) begin
      if (SLOT_W'(i) <= pos) begin
        r[i*SLOT_W +: SLOT_W] = row[(i-1)*SLOT_W +: SLOT_W];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lwbc_ram.sv @@
// ----------------------------------------------------------------------------
// lwbc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lwbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/lru_write_buffer_cache.sv @@
// ----------------------------------------------------------------------------
// lru_write_buffer_cache
// Per-bank write buffer cache with LRU order and dirty marks, run by a small
// sequencer over one shared scan/compare unit.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid_i/in_ready_o | in_req_i  (lwbc_in_t)
// out     | out | out_valid_o/out_ready_i | out_rsp_o (lwbc_out_t)
//
// Scan: write, flush and clean pick walk the whole LRU list, one list position
//   per cycle; lookup costs one registered RAM read plus one compare per slot
//   probed, up to BPB slots; read entry fetches its slot directly.
// Reset: LRU rows and page tags come back through valid bits (identity row,
//   all-ones page); no clearing pass. Span and epoch are undefined until
//   written.
// One request in flight; a finished response sits in the output register
//   while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lru_write_buffer_cache (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lwbc_pkg::lwbc_in_t  in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lwbc_pkg::lwbc_out_t      out_rsp_o
);

  localparam int unsigned SLOT_W = lwbc_pkg::SLOT_W;
  localparam int unsigned BANK_W = lwbc_pkg::BANK_W;
  localparam int unsigned ADDR_W = lwbc_pkg::ADDR_W;
  localparam int unsigned ROW_W  = lwbc_pkg::ROW_W;
  localparam int unsigned CNT_W  = lwbc_pkg::CNT_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_LRU   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_WRITE = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_DATA  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(lwbc_pkg::BPB - 1);

  logic [3:0] state_q, state_d;

  // request fields
  logic [2:0]        mode_q;
  logic [BANK_W-1:0] bank_q;
  logic [SLOT_W-1:0] slot_q;
  logic              slot_bad_q;
  logic [31:0]       page_q;
  logic [15:0]       span_q;
  logic [31:0]       epoch_q;

  // scan state
  logic [SLOT_W-1:0] idx_q, pos_q, sel_q;
  logic              fnd_q;
  logic [ROW_W-1:0]  row_q;
  lwbc_pkg::lwbc_out_t res_q;

  // per-slot and per-bank control state
  logic [lwbc_pkg::NSLOTS-1:0]  page_vld_q;
  logic [lwbc_pkg::BANKS-1:0]   lru_vld_q;
  logic [lwbc_pkg::BPB-1:0]     dirty_q [lwbc_pkg::BANKS];
  logic [CNT_W-1:0]             cnt_q   [lwbc_pkg::BANKS];
  logic [lwbc_pkg::BANKS-1:0]   stall_q;
  logic                         pvld_q, lvld_q;

  // RAM ports
  logic [ADDR_W-1:0] data_raddr, data_waddr;
  logic              data_we, lru_we;
  logic [31:0]       page_rdata, epoch_rdata;
  logic [15:0]       span_rdata;
  logic [ROW_W-1:0]  lru_rdata, lru_wdata;

  assign data_raddr = {bank_q, sel_q};
  assign data_waddr = {bank_q, slot_q};
  assign data_we    = (state_q == S_WRITE);
  assign lru_we     = (state_q == S_WRITE);
  assign lru_wdata  = lwbc_pkg::lru_promote(row_q, pos_q, slot_q);

  lwbc_ram #(.Width(32), .Depth(lwbc_pkg::NSLOTS)) u_page_ram (
    .clk_i, .we_i(data_we), .waddr_i(data_waddr), .wdata_i(page_q),
    .raddr_i(data_raddr), .rdata_o(page_rdata)
  );
  lwbc_ram #(.Width(16), .Depth(lwbc_pkg::NSLOTS)) u_span_ram (
    .clk_i, .we_i(data_we), .waddr_i(data_waddr), .wdata_i(span_q),
    .raddr_i(data_raddr), .rdata_o(span_rdata)
  );
  lwbc_ram #(.Width(32), .Depth(lwbc_pkg::NSLOTS)) u_epoch_ram (
    .clk_i, .we_i(data_we), .waddr_i(data_waddr), .wdata_i(epoch_q),
    .raddr_i(data_raddr), .rdata_o(epoch_rdata)
  );
  lwbc_ram #(.Width(ROW_W), .Depth(lwbc_pkg::BANKS)) u_lru_ram (
    .clk_i, .we_i(lru_we), .waddr_i(bank_q), .wdata_i(lru_wdata),
    .raddr_i(bank_q), .rdata_o(lru_rdata)
  );

  // never-written tags read as all ones
  logic [31:0] page_rd;
  assign page_rd = pvld_q ? page_rdata : '1;

  // shared scan unit: one LRU position per cycle
  logic [SLOT_W-1:0] cur_slot;
  logic              cur_dirty, scan_hit;
  assign cur_slot  = row_q[idx_q*SLOT_W +: SLOT_W];
  assign cur_dirty = dirty_q[bank_q][cur_slot];

  always_comb begin
    case (mode_q)
      lwbc_pkg::MODE_WRITE: scan_hit = (cur_slot == slot_q) && !fnd_q;
      lwbc_pkg::MODE_FLUSH: scan_hit = cur_dirty;
      default:              scan_hit = !cur_dirty;
    endcase
  end

  logic look_hit;
  assign look_hit = (page_rd == page_q);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_START;
      S_START: begin
        case (mode_q)
          lwbc_pkg::MODE_WRITE:  state_d = slot_bad_q ? S_DONE : S_LRU;
          lwbc_pkg::MODE_FLUSH:  state_d = stall_q[bank_q] ? S_DONE : S_LRU;
          lwbc_pkg::MODE_CLEAN:  state_d = S_LRU;
          lwbc_pkg::MODE_LOOKUP: state_d = S_FETCH;
          lwbc_pkg::MODE_READ:   state_d = slot_bad_q ? S_DONE : S_FETCH;
          default:               state_d = S_DONE;
        endcase
      end
      S_LRU:   state_d = S_SCAN;
      S_SCAN: begin
        if (idx_q == LAST) begin
          if (mode_q == lwbc_pkg::MODE_WRITE) state_d = S_WRITE;
          else if (fnd_q || scan_hit)         state_d = S_FETCH;
          else                                state_d = S_DONE;
        end
      end
      S_WRITE: state_d = S_DONE;
      S_FETCH: state_d = S_DATA;
      S_DATA: begin
        if (mode_q == lwbc_pkg::MODE_LOOKUP && !look_hit && sel_q != LAST) begin
          state_d = S_FETCH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE:  if (!out_valid_o || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      page_vld_q  <= '0;
      lru_vld_q   <= '0;
      stall_q     <= '0;
      for (int unsigned b = 0; b < lwbc_pkg::BANKS; b++) begin
        dirty_q[b] <= '0;
        cnt_q[b]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == S_START) begin
        if (mode_q == lwbc_pkg::MODE_STALL)   stall_q[bank_q] <= 1'b1;
        if (mode_q == lwbc_pkg::MODE_RELEASE) stall_q[bank_q] <= 1'b0;
      end
      if (state_q == S_WRITE) begin
        page_vld_q[data_waddr]  <= 1'b1;
        lru_vld_q[bank_q]       <= 1'b1;
        dirty_q[bank_q][slot_q] <= 1'b1;
        if (!dirty_q[bank_q][slot_q]) cnt_q[bank_q] <= cnt_q[bank_q] + 1'b1;
      end
      if (state_q == S_DATA && mode_q == lwbc_pkg::MODE_FLUSH) begin
        dirty_q[bank_q][sel_q] <= 1'b0;
        if (cnt_q[bank_q] != '0) cnt_q[bank_q] <= cnt_q[bank_q] - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    pvld_q <= page_vld_q[data_raddr];
    lvld_q <= lru_vld_q[bank_q];
    unique case (state_q)
      S_IDLE: begin
        mode_q     <= in_req_i.mode;
        bank_q     <= BANK_W'(in_req_i.bank % lwbc_pkg::BANKS);
        slot_q     <= SLOT_W'(in_req_i.buffer_index);
        slot_bad_q <= {1'b0, in_req_i.buffer_index} >= 5'(lwbc_pkg::BPB);
        page_q     <= in_req_i.page_number;
        span_q     <= in_req_i.page_span;
        epoch_q    <= in_req_i.write_epoch;
        sel_q      <= (in_req_i.mode == lwbc_pkg::MODE_LOOKUP) ? '0 :
                      SLOT_W'(in_req_i.buffer_index);
        res_q      <= '{status: lwbc_pkg::ST_NONE, default: '0};
      end
      S_START: begin
        if (mode_q == lwbc_pkg::MODE_STALL || mode_q == lwbc_pkg::MODE_RELEASE) begin
          res_q.status <= lwbc_pkg::ST_OK;
        end
        if (mode_q == lwbc_pkg::MODE_FLUSH && stall_q[bank_q]) begin
          res_q.status <= lwbc_pkg::ST_STALL;
        end
      end
      S_LRU: begin
        row_q <= lvld_q ? lru_rdata : lwbc_pkg::lru_init();
        idx_q <= '0;
        pos_q <= LAST;
        fnd_q <= 1'b0;
      end
      S_SCAN: begin
        if (scan_hit) begin
          fnd_q <= 1'b1;
          if (mode_q == lwbc_pkg::MODE_WRITE) pos_q <= idx_q;
          else                                sel_q <= cur_slot;
        end
        idx_q <= idx_q + 1'b1;
      end
      S_WRITE: begin
        res_q.status    <= lwbc_pkg::ST_OK;
        res_q.slot_out  <= 4'(slot_q);
        res_q.page_out  <= page_q;
        res_q.dirty_out <= dirty_q[bank_q][slot_q];
        res_q.span_out  <= span_q;
        res_q.epoch_out <= epoch_q;
      end
      S_DATA: begin
        if (mode_q != lwbc_pkg::MODE_LOOKUP || look_hit) begin
          res_q.status    <= lwbc_pkg::ST_OK;
          res_q.slot_out  <= 4'(sel_q);
          res_q.page_out  <= page_rd;
          res_q.dirty_out <= dirty_q[bank_q][sel_q];
          // clean pick reports no span or epoch
          res_q.span_out  <= (mode_q == lwbc_pkg::MODE_CLEAN) ? '0 : span_rdata;
          res_q.epoch_out <= (mode_q == lwbc_pkg::MODE_CLEAN) ? '0 : epoch_rdata;
        end else begin
          sel_q <= sel_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          out_rsp_o <= {res_q[$bits(lwbc_pkg::lwbc_out_t)-1:5], 5'(cnt_q[bank_q])};
        end
      end
      default: ;
    endcase
  end

  `LWBC_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1,
                   cnt_q[bank_q] <= CNT_W'(lwbc_pkg::BPB), "dirty count overflow")
  `LWBC_ASSERT_IMP(a_stall_flush, clk_i, rst_ni,
                   state_q == S_DONE && res_q.status == lwbc_pkg::ST_STALL,
                   mode_q == lwbc_pkg::MODE_FLUSH, "stalled status outside flush pick")
  `LWBC_ASSERT(a_accept_busy, clk_i, rst_ni,
               in_valid_i && in_ready_o |=> state_q == S_START, "accept did not start")
  `LWBC_ASSERT(a_write_dirty, clk_i, rst_ni,
               state_q == S_WRITE |=> dirty_q[$past(bank_q)][$past(slot_q)],
               "written slot not dirty")

endmodule

`default_nettype wire

@@ tb/tb_lru_write_buffer_cache.sv @@
// ----------------------------------------------------------------------------
// tb_lru_write_buffer_cache
// Drives random and directed requests into the write buffer cache and checks
// every response against an in-bench model of banks, LRU lists and dirty marks.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_write_buffer_cache;
  timeunit 1ns;
  timeprecision 1ps;
  import lwbc_pkg::*;

  localparam int unsigned NB = 8;
  localparam int unsigned NS = 16;

  // Buffer cache shadow plus the queue of responses still owed by the block.
  class cache_scoreboard;
    logic [3:0]  lru [NB][NS];
    logic [31:0] pg  [NB][NS];
    logic [15:0] sp  [NB][NS];
    logic [31:0] ep  [NB][NS];
    bit          wr  [NB][NS];
    bit          dty [NB][NS];
    bit          stl [NB];
    int unsigned ndirty [NB];
    lwbc_out_t   owed [$];
    int unsigned errors, checked;

    function new();
      for (int b = 0; b < NB; b++) begin
        stl[b] = 0;
        ndirty[b] = 0;
        for (int i = 0; i < NS; i++) begin
          lru[b][i] = 4'(i);
          pg[b][i] = '1;
          sp[b][i] = '0;
          ep[b][i] = '0;
          wr[b][i] = 0;
          dty[b][i] = 0;
        end
      end
    endfunction

    function void fill(ref lwbc_out_t r, input int b, input int s, input bit full);
      r.status = ST_OK;
      r.slot_out = 4'(s);
      r.page_out = pg[b][s];
      r.dirty_out = dty[b][s];
      r.span_out = full ? sp[b][s] : '0;
      r.epoch_out = full ? ep[b][s] : '0;
    endfunction

    // Apply one accepted request and queue the response it must produce.
    function void note_request(lwbc_in_t q);
      lwbc_out_t r;
      int b, s, pos, hit;
      r = '0;
      r.status = ST_NONE;
      b = q.bank % NB;
      s = q.buffer_index;
      case (q.mode)
        MODE_WRITE: begin
          r.dirty_out = dty[b][s];
          pg[b][s] = q.page_number;
          sp[b][s] = q.page_span;
          ep[b][s] = q.write_epoch;
          wr[b][s] = 1;
          if (!dty[b][s]) ndirty[b]++;
          dty[b][s] = 1;
          pos = NS - 1;
          for (int i = NS - 1; i >= 0; i--) if (lru[b][i] == 4'(s)) pos = i;
          for (int i = pos; i > 0; i--) lru[b][i] = lru[b][i-1];
          lru[b][0] = 4'(s);
          r.status = ST_OK;
          r.slot_out = 4'(s);
          r.page_out = q.page_number;
          r.span_out = q.page_span;
          r.epoch_out = q.write_epoch;
        end
        MODE_FLUSH: begin
          if (stl[b]) r.status = ST_STALL;
          else begin
            hit = -1;
            for (int i = 0; i < NS; i++) if (dty[b][lru[b][i]]) hit = lru[b][i];
            if (hit >= 0) begin
              fill(r, b, hit, 1);
              dty[b][hit] = 0;
              if (ndirty[b] > 0) ndirty[b]--;
            end
          end
        end
        MODE_LOOKUP: begin
          hit = -1;
          for (int i = NS - 1; i >= 0; i--) if (pg[b][i] == q.page_number) hit = i;
          if (hit >= 0) fill(r, b, hit, 1);
        end
        MODE_CLEAN: begin
          hit = -1;
          for (int i = 0; i < NS; i++) if (!dty[b][lru[b][i]]) hit = lru[b][i];
          if (hit >= 0) fill(r, b, hit, 0);
        end
        MODE_READ: fill(r, b, s, 1);
        MODE_STALL: begin
          stl[b] = 1;
          r.status = ST_OK;
        end
        MODE_RELEASE: begin
          stl[b] = 0;
          r.status = ST_OK;
        end
        default: ;
      endcase
      r.dirty_total = 5'(ndirty[b]);
      owed.push_back(r);
    endfunction

    function void check_response(lwbc_out_t a);
      lwbc_out_t e;
      checked++;
      if (owed.size() == 0) begin
        $error("response with none outstanding: %p", a);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.slot_out !== e.slot_out) begin
        $error("slot_out exp %0d got %0d", e.slot_out, a.slot_out); errors++;
      end
      if (a.page_out !== e.page_out) begin
        $error("page_out exp %h got %h", e.page_out, a.page_out); errors++;
      end
      if (a.dirty_out !== e.dirty_out) begin
        $error("dirty_out exp %0d got %0d", e.dirty_out, a.dirty_out); errors++;
      end
      if (a.span_out !== e.span_out) begin
        $error("span_out exp %h got %h", e.span_out, a.span_out); errors++;
      end
      if (a.epoch_out !== e.epoch_out) begin
        $error("epoch_out exp %h got %h", e.epoch_out, a.epoch_out); errors++;
      end
      if (a.dirty_total !== e.dirty_total) begin
        $error("dirty_total exp %0d got %0d", e.dirty_total, a.dirty_total); errors++;
      end
    endfunction
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_ready_o;
  lwbc_in_t  in_req_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 0;
  lwbc_out_t out_rsp_o;

  cache_scoreboard sb = new();
  int unsigned sent = 0;
  int unsigned mode_hits [8];
  bit          rx_steady = 0;

  lru_write_buffer_cache dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: worst case is far below this (under 650 requests, with receiver stalls).
  initial begin
    #20ms;
    $display("lru_write_buffer_cache: mismatch");
    $finish;
  end

  // Monitor: requests are noted at acceptance, responses checked at acceptance.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_request(in_req_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_rsp_o);
  end

  // Receiver: own stall pattern, with quiet stretches of constant readiness.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (rx_steady || (phase % 400) < 80) out_ready_i <= 1'b1;
      else if ((phase % 400) < 200) out_ready_i <= ($urandom_range(0, 3) != 0);
      else out_ready_i <= ($urandom_range(0, 2) == 0);
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(lwbc_in_t q);
    in_req_i <= q;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    mode_hits[q.mode]++;
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Build a request; page numbers are drawn from a small pool so lookups hit.
  // Reads are limited to written slots; lookups never ask for the all-ones page.
  function automatic lwbc_in_t make_request(int m, int b, int s);
    lwbc_in_t q;
    q.mode = 3'(m);
    q.bank = 3'(b);
    q.buffer_index = 4'(s);
    q.page_number = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 7));
    q.page_span = 16'($urandom());
    q.write_epoch = $urandom();
    if (m == MODE_READ && !sb.wr[b][s]) q.mode = MODE_CLEAN;
    if (m == MODE_LOOKUP && q.page_number == '1) q.page_number = 32'd1;
    return q;
  endfunction

  // At least one edge passes, so the last accepted request is already noted.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.owed.size() != 0);
  endtask

  initial begin
    lwbc_in_t q;
    int m, b, s, burst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-bank picks, extremes of every field, stall then flush.
    send_request(make_request(MODE_FLUSH, 0, 0));
    send_request(make_request(MODE_CLEAN, 0, 0));
    q = make_request(MODE_WRITE, 7, 15);
    q.page_number = '1; q.page_span = '1; q.write_epoch = '1;
    send_request(q);
    q = make_request(MODE_WRITE, 7, 0);
    q.page_number = '0; q.page_span = '0; q.write_epoch = '0;
    send_request(q);
    send_request(make_request(MODE_WRITE, 7, 15));
    q = make_request(MODE_LOOKUP, 7, 0); q.page_number = '0; send_request(q);
    q = make_request(MODE_LOOKUP, 3, 0); q.page_number = 32'h1234_5678; send_request(q);
    send_request(make_request(MODE_READ, 7, 15));
    send_request(make_request(MODE_READ, 7, 0));
    send_request(make_request(MODE_STALL, 7, 0));
    send_request(make_request(MODE_FLUSH, 7, 0));
    send_request(make_request(MODE_RELEASE, 7, 0));
    send_request(make_request(MODE_FLUSH, 7, 0));
    send_request(make_request(MODE_FLUSH, 7, 0));
    send_request(make_request(MODE_FLUSH, 7, 0));
    q = make_request(MODE_WRITE, 7, 0); q.mode = 3'd7; send_request(q);
    // Fill bank 1 entirely so clean pick finds nothing.
    for (int i = 0; i < NS; i++) send_request(make_request(MODE_WRITE, 1, i));
    send_request(make_request(MODE_CLEAN, 1, 0));
    drain();

    // Random bursts; requests focused on a few banks keep the LRU lists busy.
    while (sent < 620) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst; k++) begin
        m = $urandom_range(0, 99);
        m = (m < 35) ? MODE_WRITE : (m < 50) ? MODE_FLUSH : (m < 62) ? MODE_LOOKUP :
            (m < 72) ? MODE_CLEAN : (m < 84) ? MODE_READ : (m < 90) ? MODE_STALL :
            (m < 97) ? MODE_RELEASE : 7;
        b = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 2) : $urandom_range(0, 7);
        s = $urandom_range(0, 15);
        send_request(make_request(m, b, s));
      end
      if (sent > 300 && sent < 330) drain();
      if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 30));
    end

    drain();
    rx_steady = 1;
    repeat (50) @(posedge clk_i);
    $display("Covered %0d requests (w%0d f%0d l%0d c%0d r%0d s%0d x%0d bad%0d), %0d responses.",
             sent, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
             mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7], sb.checked);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("lru_write_buffer_cache: match");
    end else begin
      $display("lru_write_buffer_cache: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lwbc_pkg.sv
hw/rtl/lwbc_ram.sv
hw/rtl/lru_write_buffer_cache.sv
tb/tb_lru_write_buffer_cache.sv
